@@ hw/rtl/rtcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rtcs_pkg
// Shared types and constants of the three-wire RTC time sequencer.
// ----------------------------------------------------------------------------
package rtcs_pkg;

	// func codes on the input stream
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_SET  = 2'd1;
	localparam logic [1:0] FUNC_GET  = 2'd2;

	localparam int NUM_TIME_REGS = 7;

	// register addresses on the serial bus
	localparam logic [7:0] ADDR_WP      = 8'h8E;
	localparam logic [3:0] ADDR_HI      = 4'h8;
	localparam logic [7:0] WP_OFF       = 8'h00;
	localparam logic [7:0] WP_ON        = 8'h80;

	localparam logic [3:0] SET_TXN_COUNT = 4'd9;
	localparam logic [3:0] GET_TXN_COUNT = 4'd7;

	// classified word kinds
	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_SET,
		KIND_GET
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_SET,
		MODE_GET
	} mode_t;

	typedef logic [NUM_TIME_REGS-1:0][7:0] time_bytes_t;

	// one queued word: kind, sampled pin, and register bytes ready to send
	typedef struct packed {
		kind_t       kind;
		logic        dat;
		time_bytes_t wbytes;
	} entry_t;

endpackage

@@ hw/rtl/rtcs_front.sv @@
// ----------------------------------------------------------------------------
// rtcs_front
// Classifies input words and converts set-time values to register bytes.
// ----------------------------------------------------------------------------
module rtcs_front
	import rtcs_pkg::*;
(
	input  logic [47:0] in_data,
	input  logic [1:0]  in_func,
	output entry_t      entry
);

	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [6:0]  x;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		x    = (v > 7'd99) ? 7'd99 : v;
		prod = 15'(x) * 15'd205;
		tens = prod[14:11];
		ones = x - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

	always_comb begin
		case (in_func)
			FUNC_SET: entry.kind = KIND_SET;
			FUNC_GET: entry.kind = KIND_GET;
			default:  entry.kind = KIND_TICK;
		endcase
		entry.dat       = in_data[0];
		entry.wbytes[0] = to_bcd(in_data[7:1]);
		entry.wbytes[1] = to_bcd(in_data[14:8]);
		entry.wbytes[2] = to_bcd(in_data[21:15]);
		entry.wbytes[3] = to_bcd(in_data[28:22]);
		entry.wbytes[4] = to_bcd(in_data[35:29]);
		entry.wbytes[5] = {5'd0, in_data[45:43]};
		entry.wbytes[6] = to_bcd(in_data[42:36]);
	end

endmodule

@@ hw/rtl/rtcs_queue.sv @@
// ----------------------------------------------------------------------------
// rtcs_queue
// Short FIFO of classified words between the front and the sequencer.
// ----------------------------------------------------------------------------
module rtcs_queue
	import rtcs_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output entry_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == FULLC);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/rtcs_back.sv @@
// ----------------------------------------------------------------------------
// rtcs_back
// Pin sequencer: runs write and read transactions one pin step per word.
// ----------------------------------------------------------------------------
module rtcs_back
	import rtcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  entry_t      q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_data
);

	function automatic logic [7:0] from_bcd(input logic [7:0] b);
		return {b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
	endfunction

	mode_t       mode_q, mode_n, mode_e;
	logic [3:0]  txn_q, txn_n, txn_e, txn_inc, txn_m1;
	logic [5:0]  tick_q, tick_n, tick_e;
	logic [7:0]  shift_q, shift_n, shift_b, addr, wdata;
	time_bytes_t wbytes_q, rbytes_q;
	logic        wcap, rwe, active, high;
	logic        ce, sclk, dout, drive, valid;
	logic [55:0] tfields;
	logic        vld_q;
	logic [63:0] data_q;

	assign q_pop     = !q_empty && (!vld_q || out_ready);
	assign out_valid = vld_q;
	assign out_data  = data_q;

	always_comb begin
		mode_e  = mode_q;
		txn_e   = txn_q;
		tick_e  = tick_q;
		wcap    = 1'b0;
		active  = 1'b1;
		rwe     = 1'b0;
		ce      = 1'b0;
		sclk    = 1'b0;
		dout    = 1'b0;
		drive   = 1'b0;
		valid   = 1'b0;
		tfields = '0;
		if (mode_q == MODE_IDLE) begin
			case (q_head.kind)
				KIND_SET: begin
					mode_e = MODE_SET;
					wcap   = 1'b1;
				end
				KIND_GET: mode_e = MODE_GET;
				default:  active = 1'b0;
			endcase
			txn_e  = '0;
			tick_e = '0;
		end
		mode_n  = mode_e;
		txn_n   = txn_e;
		tick_n  = tick_e;
		txn_inc = txn_e + 1'b1;
		txn_m1  = txn_e - 1'b1;

		// transaction address and write data
		if (mode_e == MODE_GET) begin
			addr = {ADDR_HI, txn_e[2:0], 1'b1};
		end else if (txn_e == '0 || txn_e[3]) begin
			addr = ADDR_WP;
		end else begin
			addr = {ADDR_HI, txn_m1[2:0], 1'b0};
		end
		if (txn_e == '0) begin
			wdata = WP_OFF;
		end else if (txn_e[3]) begin
			wdata = WP_ON;
		end else begin
			wdata = wbytes_q[txn_m1[2:0]];
		end

		high    = !tick_e[0];
		shift_b = (tick_e == '0) ? addr : shift_q;
		shift_n = shift_q;

		if (active) begin
			if (!tick_e[5]) begin
				shift_n = shift_b;
				ce      = 1'b1;
				sclk    = high;
				if (!tick_e[4] || mode_e == MODE_SET) begin
					drive = 1'b1;
					dout  = shift_b[0];
					if (!high) begin
						shift_n = (tick_e == 6'd15 && mode_e == MODE_SET) ? wdata
							: {1'b0, shift_b[7:1]};
					end
				end else begin
					// capture read bit at the MSB on the clock-high step
					if (high) begin
						shift_n = {q_head.dat, shift_b[7:1]};
					end
					rwe = (tick_e == 6'd31) && (txn_e < GET_TXN_COUNT);
				end
				tick_n = tick_e + 1'b1;
			end else begin
				txn_n  = txn_inc;
				tick_n = '0;
				if (txn_inc >= ((mode_e == MODE_SET) ? SET_TXN_COUNT : GET_TXN_COUNT)) begin
					if (mode_e == MODE_GET) begin
						valid   = 1'b1;
						tfields = {from_bcd(rbytes_q[6]), rbytes_q[5],
							from_bcd(rbytes_q[4]), from_bcd(rbytes_q[3]),
							from_bcd(rbytes_q[2]), from_bcd(rbytes_q[1]),
							from_bcd(rbytes_q[0])};
					end
					mode_n = MODE_IDLE;
					txn_n  = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			txn_q   <= '0;
			tick_q  <= '0;
			shift_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				mode_q  <= mode_n;
				txn_q   <= txn_n;
				tick_q  <= tick_n;
				shift_q <= shift_n;
				vld_q   <= 1'b1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= {3'b000, tfields, valid, drive, dout, sclk, ce};
			if (wcap) begin
				wbytes_q <= q_head.wbytes;
			end
			if (rwe) begin
				rbytes_q[txn_e[2:0]] <= shift_b;
			end
		end
	end

endmodule

@@ hw/rtl/rtc_three_wire_time_sequencer.sv @@
// ----------------------------------------------------------------------------
// rtc_three_wire_time_sequencer
// Three-wire serial RTC master: sets and reads the time, one pin step a word.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Contents
// s_axis    in   s_axis_tvalid/tready   tick, set-time or get-time word
// m_axis    out  m_axis_tvalid/tready   pin levels and decoded time
//
// Every input word yields exactly one output word. Throughput is one word
// per cycle while the output is ready; words pass the queue and output register.
// A set-time run takes 9 x 33 words, a get-time run 7 x 33 words.
// Reset clears the sequencer state, the queue pointers and the output valid flag.
// The queue absorbs up to QUEUE_DEPTH words while the output side stalls.
// ----------------------------------------------------------------------------
module rtc_three_wire_time_sequencer
	import rtcs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// sampled_dat, seconds_in, minutes_in, hours_in, day_in, month_in, year_in,
	// weekday_in, zero fill
	input  logic [47:0] s_axis_tdata,
	// func
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// ce_pin, sclk_pin, dat_out, dat_drive, time_valid, seconds_out,
	// minutes_out, hours_out, day_out, month_out, weekday_out, year_out,
	// zero fill
	output logic [63:0] m_axis_tdata
);

	entry_t front_entry, head;
	logic   full, empty, push, pop;

	assign s_axis_tready = !full;
	assign push          = s_axis_tvalid && !full;

	rtcs_front u_front (
		.in_data (s_axis_tdata),
		.in_func (s_axis_tuser),
		.entry   (front_entry)
	);

	rtcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	rtcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_head    (head),
		.q_pop     (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
